// ===== src/assert_macros.svh =====
// Assertion macros shared by the checker modules.
// Expects clk and arst_n in the scope of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define TSC_ASSERT_NOW(label, ant, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ant) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define TSC_ASSERT_NEXT(label, ant, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ant) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/tsc_pkg.sv =====
// Package for the Taylor sine/cosine core: payload and command types,
// opcodes, operand select codes and the reciprocal table. No dependencies.
package tsc_pkg;

	localparam int TC_W  = 5;
	localparam int K_W   = 5;
	localparam int ACC_W = 128;
	localparam int MAG_W = 48;

	localparam logic [MAG_W-1:0] MAG_MAX = 48'h7FFF_FFFF_FFFF;

	localparam logic OP_SINE   = 1'b0;
	localparam logic OP_COSINE = 1'b1;

	typedef struct packed {
		logic               opcode;
		logic signed [31:0] angle;
	} arg_t;

	typedef struct packed {
		logic signed [31:0] value;
		logic               saturated;
	} res_t;

	localparam logic [2:0] SEL_SQ  = 3'd0;
	localparam logic [2:0] SEL_T00 = 3'd1;
	localparam logic [2:0] SEL_T01 = 3'd2;
	localparam logic [2:0] SEL_T10 = 3'd3;
	localparam logic [2:0] SEL_T11 = 3'd4;
	localparam logic [2:0] SEL_R0  = 3'd5;
	localparam logic [2:0] SEL_R1  = 3'd6;

	localparam logic [1:0] SH_0  = 2'd0;
	localparam logic [1:0] SH_32 = 2'd1;
	localparam logic [1:0] SH_64 = 2'd2;

	typedef struct packed {
		logic           load;
		logic           mul_en;
		logic [2:0]     sel;
		logic           first;
		logic           x2_ld;
		logic           upd;
		logic           res_ld;
		logic [K_W-1:0] k;
	} cmd_t;

	typedef struct packed {
		logic cosine;
	} sts_t;

	// round(2^32 / (k*(k+1))), 32 fraction bits
	localparam logic [31:0] RECIP [32] = '{
		32'd0,         32'd2147483648, 32'd715827883, 32'd357913941,
		32'd214748365, 32'd143165577,  32'd102261126, 32'd76695845,
		32'd59652324,  32'd47721859,   32'd39045157,  32'd32537631,
		32'd27531842,  32'd23598721,   32'd20452225,  32'd17895697,
		32'd15790321,  32'd14035841,   32'd12558384,  32'd11302546,
		32'd10226113,  32'd9296466,    32'd8488078,   32'd7780738,
		32'd7158279,   32'd6607642,    32'd6118187,   32'd5681174,
		32'd5289369,   32'd4936744,    32'd4618244,   32'd4329604
	};

endpackage

// ===== src/tsc_datapath.sv =====
// Datapath: shared 32x32 multiplier, 128-bit partial product accumulator,
// term and sum registers, output register. Uses tsc_pkg.
module tsc_datapath #(
	parameter int FRAC_BITS = 27
) (
	input  logic          clk,
	input  logic          arst_n,
	input  tsc_pkg::cmd_t cmd,
	input  tsc_pkg::arg_t arg,
	output tsc_pkg::sts_t sts,
	output tsc_pkg::res_t res
);

	localparam int MW = tsc_pkg::MAG_W;
	localparam int AW = tsc_pkg::ACC_W;

	logic [31:0]        mag_q;
	logic               neg_q;
	logic               cos_q;
	logic [MW-1:0]      x2_q;
	logic [MW-1:0]      tmag_q;
	logic               tneg_q;
	logic signed [MW-1:0] sum_q;
	logic               sat_q;
	logic [63:0]        prod_s1;
	logic [1:0]         sh_s1;
	logic               first_s1;
	logic               acc_en_s1;
	logic [AW-1:0]      acc_q;
	tsc_pkg::res_t      res_q;

	logic [AW-1:0]      p_full;
	logic               p_ovf;
	logic [63:0]        p_val;
	logic [31:0]        rcp;
	logic [31:0]        mul_a;
	logic [31:0]        mul_b;
	logic [1:0]         mul_sh;
	logic [63:0]        mul_p;
	logic [AW-1:0]      addend;
	logic               q_ovf;
	logic [MW-1:0]      q;
	logic               tneg_n;
	logic [MW:0]        term_w;
	logic [MW:0]        sum_w;
	logic               sum_ovf;
	logic [MW-1:0]      sum_n;
	logic [MW-1:0]      t_init;
	logic               fits32;
	logic [31:0]        angle_u;

	assign p_full = acc_q >> FRAC_BITS;
	assign p_ovf  = |p_full[AW-1:64];
	assign p_val  = p_ovf ? '1 : p_full[63:0];
	assign rcp    = tsc_pkg::RECIP[cmd.k];

	always_comb begin
		mul_a  = '0;
		mul_b  = '0;
		mul_sh = tsc_pkg::SH_0;
		case (cmd.sel)
			tsc_pkg::SEL_SQ: begin
				mul_a = mag_q;
				mul_b = mag_q;
			end
			tsc_pkg::SEL_T00: begin
				mul_a = tmag_q[31:0];
				mul_b = x2_q[31:0];
			end
			tsc_pkg::SEL_T01: begin
				mul_a  = tmag_q[31:0];
				mul_b  = 32'(x2_q[MW-1:32]);
				mul_sh = tsc_pkg::SH_32;
			end
			tsc_pkg::SEL_T10: begin
				mul_a  = 32'(tmag_q[MW-1:32]);
				mul_b  = x2_q[31:0];
				mul_sh = tsc_pkg::SH_32;
			end
			tsc_pkg::SEL_T11: begin
				mul_a  = 32'(tmag_q[MW-1:32]);
				mul_b  = 32'(x2_q[MW-1:32]);
				mul_sh = tsc_pkg::SH_64;
			end
			tsc_pkg::SEL_R0: begin
				mul_a = p_val[31:0];
				mul_b = rcp;
			end
			tsc_pkg::SEL_R1: begin
				mul_a  = p_val[63:32];
				mul_b  = rcp;
				mul_sh = tsc_pkg::SH_32;
			end
			default: begin
				mul_a = '0;
			end
		endcase
	end

	assign mul_p = mul_a * mul_b;

	always_comb begin
		case (sh_s1)
			tsc_pkg::SH_32: addend = AW'(prod_s1) << 32;
			tsc_pkg::SH_64: addend = AW'(prod_s1) << 64;
			default:        addend = AW'(prod_s1);
		endcase
	end

	// new term magnitude and running sum
	assign q_ovf  = |acc_q[AW-1:79];
	assign q      = q_ovf ? tsc_pkg::MAG_MAX : acc_q[79:32];
	assign tneg_n = ~tneg_q;
	assign term_w = tneg_n ? -{1'b0, q} : {1'b0, q};
	assign sum_w  = {sum_q[MW-1], sum_q} + term_w;
	assign sum_ovf = sum_w[MW] != sum_w[MW-1];
	assign sum_n  = sum_ovf ? (sum_w[MW] ? {1'b1, {(MW-1){1'b0}}} : tsc_pkg::MAG_MAX)
		: sum_w[MW-1:0];

	assign t_init  = cos_q ? (MW'(1) << FRAC_BITS) : MW'(mag_q);
	assign fits32  = (sum_q[MW-1:31] == '0) || (sum_q[MW-1:31] == '1);
	assign angle_u = arg.angle;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_en_s1 <= 1'b0;
		end else begin
			acc_en_s1 <= cmd.mul_en;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mag_q <= arg.angle[31] ? (~angle_u + 32'd1) : angle_u;
			neg_q <= arg.angle[31];
			cos_q <= (arg.opcode == tsc_pkg::OP_COSINE);
			sat_q <= 1'b0;
		end
		if (cmd.mul_en) begin
			prod_s1  <= mul_p;
			sh_s1    <= mul_sh;
			first_s1 <= cmd.first;
			if (cmd.sel == tsc_pkg::SEL_R0 && p_ovf) begin
				sat_q <= 1'b1;
			end
		end
		if (acc_en_s1) begin
			acc_q <= first_s1 ? addend : acc_q + addend;
		end
		if (cmd.x2_ld) begin
			x2_q   <= p_full[MW-1:0];
			tmag_q <= t_init;
			tneg_q <= cos_q ? 1'b0 : neg_q;
			sum_q  <= (!cos_q && neg_q) ? -t_init : t_init;
		end
		if (cmd.upd) begin
			tmag_q <= q;
			tneg_q <= tneg_n;
			sum_q  <= sum_n;
			if (q_ovf || sum_ovf) begin
				sat_q <= 1'b1;
			end
		end
		if (cmd.res_ld) begin
			res_q.value     <= fits32 ? sum_q[31:0]
				: (sum_q[MW-1] ? 32'sh8000_0000 : 32'sh7FFF_FFFF);
			res_q.saturated <= sat_q | ~fits32;
		end
	end

	assign sts.cosine = cos_q;
	assign res        = res_q;

endmodule

// ===== src/tsc_ctrl.sv =====
// Controller: sequences setup, per-term multiply steps and result hand-off.
// Holds the term_count register and the result valid flag. Uses tsc_pkg.
module tsc_ctrl #(
	parameter int MAX_TERMS = 16
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [tsc_pkg::TC_W-1:0] cfg_wdata,
	input  logic                     arg_valid,
	output logic                     arg_stall,
	output logic                     res_valid,
	input  logic                     res_stall,
	input  tsc_pkg::sts_t            sts,
	output tsc_pkg::cmd_t            cmd
);

	localparam int CNT_W = $clog2(MAX_TERMS + 1);
	localparam int K_W   = tsc_pkg::K_W;

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_SQ   = 4'd1;
	localparam logic [3:0] ST_SQW  = 4'd2;
	localparam logic [3:0] ST_X2   = 4'd3;
	localparam logic [3:0] ST_T0   = 4'd4;
	localparam logic [3:0] ST_T1   = 4'd5;
	localparam logic [3:0] ST_T2   = 4'd6;
	localparam logic [3:0] ST_T3   = 4'd7;
	localparam logic [3:0] ST_TW   = 4'd8;
	localparam logic [3:0] ST_R0   = 4'd9;
	localparam logic [3:0] ST_R1   = 4'd10;
	localparam logic [3:0] ST_RW   = 4'd11;
	localparam logic [3:0] ST_UPD  = 4'd12;
	localparam logic [3:0] ST_FIN  = 4'd13;

	logic [3:0]               state_q;
	logic [3:0]               state_d;
	logic [tsc_pkg::TC_W-1:0] tc_q;
	logic [CNT_W-1:0]         cnt_q;
	logic [CNT_W-1:0]         n_q;
	logic [CNT_W-1:0]         cnt_clamp;
	logic                     res_valid_q;
	logic                     accept;
	logic                     slot_free;

	assign arg_stall = state_q != ST_IDLE;
	assign accept    = arg_valid && !arg_stall;
	assign slot_free = !res_valid_q || !res_stall;
	assign res_valid = res_valid_q;

	always_comb begin
		if (tc_q == '0) begin
			cnt_clamp = CNT_W'(1);
		end else if (int'(tc_q) > MAX_TERMS) begin
			cnt_clamp = CNT_W'(MAX_TERMS);
		end else begin
			cnt_clamp = CNT_W'(tc_q);
		end
	end

	always_comb begin
		cmd        = '0;
		cmd.k      = K_W'({n_q, 1'b0}) - K_W'(sts.cosine);
		cmd.sel    = tsc_pkg::SEL_SQ;
		state_d    = state_q;
		case (state_q)
			ST_IDLE: begin
				cmd.load = accept;
				if (accept) begin
					state_d = ST_SQ;
				end
			end
			ST_SQ: begin
				cmd.mul_en = 1'b1;
				cmd.first  = 1'b1;
				state_d    = ST_SQW;
			end
			ST_SQW: state_d = ST_X2;
			ST_X2: begin
				cmd.x2_ld = 1'b1;
				state_d   = (cnt_q == CNT_W'(1)) ? ST_FIN : ST_T0;
			end
			ST_T0: begin
				cmd.mul_en = 1'b1;
				cmd.first  = 1'b1;
				cmd.sel    = tsc_pkg::SEL_T00;
				state_d    = ST_T1;
			end
			ST_T1: begin
				cmd.mul_en = 1'b1;
				cmd.sel    = tsc_pkg::SEL_T01;
				state_d    = ST_T2;
			end
			ST_T2: begin
				cmd.mul_en = 1'b1;
				cmd.sel    = tsc_pkg::SEL_T10;
				state_d    = ST_T3;
			end
			ST_T3: begin
				cmd.mul_en = 1'b1;
				cmd.sel    = tsc_pkg::SEL_T11;
				state_d    = ST_TW;
			end
			ST_TW: state_d = ST_R0;
			ST_R0: begin
				cmd.mul_en = 1'b1;
				cmd.first  = 1'b1;
				cmd.sel    = tsc_pkg::SEL_R0;
				state_d    = ST_R1;
			end
			ST_R1: begin
				cmd.mul_en = 1'b1;
				cmd.sel    = tsc_pkg::SEL_R1;
				state_d    = ST_RW;
			end
			ST_RW: state_d = ST_UPD;
			ST_UPD: begin
				cmd.upd = 1'b1;
				state_d = (n_q + CNT_W'(1) == cnt_q) ? ST_FIN : ST_T0;
			end
			ST_FIN: begin
				cmd.res_ld = slot_free;
				if (slot_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			tc_q        <= tsc_pkg::TC_W'(5);
			cnt_q       <= '0;
			n_q         <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				tc_q <= cfg_wdata;
			end
			if (accept) begin
				cnt_q <= cnt_clamp;
			end
			if (state_q == ST_X2) begin
				n_q <= CNT_W'(1);
			end else if (state_q == ST_UPD) begin
				n_q <= n_q + CNT_W'(1);
			end
			if (cmd.res_ld) begin
				res_valid_q <= 1'b1;
			end else if (res_valid_q && !res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ===== src/taylor_sine_cosine_core.sv =====
// Top level of the Taylor series sine/cosine core.
// Instantiates tsc_ctrl and tsc_datapath; uses tsc_pkg.
//
//   channel  payload            handshake
//   arg      tsc_pkg::arg_t     arg_valid / arg_stall
//   res      tsc_pkg::res_t     res_valid / res_stall
//   cfg      cfg_wdata (5 bit)  cfg_we, no wait
//
// One item at a time: a new arg is taken only in idle, and N is the term_count clamped to
// 1..MAX_TERMS at the accept; res_valid rises as the controller returns to idle.
// Each term is four 32x32 partial products for t*x^2 and two for the reciprocal multiply,
// all through the one shared multiplier.
// A finished result sits in the output register; the next item is taken meanwhile and,
// when done, waits in its last state while the earlier result is stalled.
// Reset is asynchronous, active low; term_count resets to 5.
module taylor_sine_cosine_core #(
	parameter int MAX_TERMS = 16,
	parameter int FRAC_BITS = 27
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [tsc_pkg::TC_W-1:0] cfg_wdata,
	input  logic                     arg_valid,
	output logic                     arg_stall,
	input  tsc_pkg::arg_t            arg,
	output logic                     res_valid,
	input  logic                     res_stall,
	output tsc_pkg::res_t            res
);

	tsc_pkg::cmd_t cmd;
	tsc_pkg::sts_t sts;

	tsc_ctrl #(
		.MAX_TERMS (MAX_TERMS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.arg_valid (arg_valid),
		.arg_stall (arg_stall),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	tsc_datapath #(
		.FRAC_BITS (FRAC_BITS)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.arg    (arg),
		.sts    (sts),
		.res    (res)
	);

endmodule

// ===== src/tsc_checker.sv =====
// Port-level checker for taylor_sine_cosine_core, bound to the top level.
// Uses tsc_pkg and assert_macros.svh.
`include "assert_macros.svh"

module tsc_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          arg_valid,
	input logic          arg_stall,
	input tsc_pkg::arg_t arg,
	input logic          res_valid,
	input logic          res_stall,
	input tsc_pkg::res_t res
);

	`TSC_ASSERT_NEXT(a_arg_hold, arg_valid && arg_stall, arg_valid && $stable(arg), "arg moved")
	`TSC_ASSERT_NEXT(a_res_hold, res_valid && res_stall, res_valid && $stable(res), "res moved")
	`TSC_ASSERT_NEXT(a_busy_after_xfer, arg_valid && !arg_stall, arg_stall, "input not blocked")
	`TSC_ASSERT_NEXT(a_no_instant_res, arg_valid && !arg_stall, !$rose(res_valid), "early result")
	`TSC_ASSERT_NOW(a_free_on_res, $rose(res_valid), !arg_stall && $past(arg_stall), "stray result")

endmodule

bind taylor_sine_cosine_core tsc_checker u_tsc_checker (.*);
